FILE: src/hss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hss_pkg;

   localparam int CoordW    = 16;
   localparam int DeltaW    = 17;
   localparam int SqW       = 34;
   localparam int ExpW      = 6;
   localparam int MantW     = 32;
   localparam int LogFrac   = 24;
   localparam int LogW      = ExpW + LogFrac;
   localparam int CordW     = 32;
   localparam int DiffW     = CordW + 1;
   localparam int WrapW     = 35;
   localparam int ProdW     = 62;
   localparam int LogOutW   = 21;
   localparam int AngOutW   = 19;
   localparam int NumCells  = LogFrac;
   localparam int CordicStagesDef = 18;

   localparam logic signed [CordW-1:0] HalfPi   = 32'sd843314857;
   localparam logic signed [WrapW-1:0] TwoPi    = 35'sd3373259426;
   localparam logic [31:0]             HalfLn2  = 32'd1488522236;

   typedef struct packed {
      logic signed [CordW-1:0] x;
      logic signed [CordW-1:0] y;
      logic signed [CordW-1:0] z;
      logic [MantW-1:0]        m;
      logic [ExpW-1:0]         e;
      logic [LogFrac-1:0]      frac;
   } lane_type;

   typedef struct packed {
      lane_type a;
      lane_type b;
      logic     degen;
   } item_type;

   // atan(2^-i), radians Q.29
   function automatic logic signed [CordW-1:0] atan_q29(input int unsigned i);
      case (i)
         0:  return 32'sd421657428;
         1:  return 32'sd248918915;
         2:  return 32'sd131521918;
         3:  return 32'sd66762579;
         4:  return 32'sd33510843;
         5:  return 32'sd16771758;
         6:  return 32'sd8387925;
         7:  return 32'sd4194219;
         8:  return 32'sd2097141;
         9:  return 32'sd1048575;
         10: return 32'sd524288;
         11: return 32'sd262144;
         12: return 32'sd131072;
         13: return 32'sd65536;
         14: return 32'sd32768;
         15: return 32'sd16384;
         16: return 32'sd8192;
         17: return 32'sd4096;
         18: return 32'sd2048;
         19: return 32'sd1024;
         20: return 32'sd512;
         21: return 32'sd256;
         22: return 32'sd128;
         23: return 32'sd64;
         default: return 32'sd0;
      endcase
   endfunction

endpackage
`default_nettype wire

FILE: src/homotopy_segment_signature_top.sv
// Stages between req accept and rsp_valid: 4 front-end, 24 cells, 3 back-end.
// Each cell does a log2 squaring step, and a CORDIC step if STAGE < CORDIC_STAGES.
// Throughput: one word per cycle; the whole pipe holds only while a result waits.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module homotopy_segment_signature_top #(
   parameter int CORDIC_STAGES = hss_pkg::CordicStagesDef
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [hss_pkg::CoordW-1:0]    req_pole_x,
   input  wire logic signed [hss_pkg::CoordW-1:0]    req_pole_y,
   input  wire logic signed [hss_pkg::CoordW-1:0]    req_start_x,
   input  wire logic signed [hss_pkg::CoordW-1:0]    req_start_y,
   input  wire logic signed [hss_pkg::CoordW-1:0]    req_end_x,
   input  wire logic signed [hss_pkg::CoordW-1:0]    req_end_y,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [hss_pkg::LogOutW-1:0]        rsp_log_ratio,
   output logic signed [hss_pkg::AngOutW-1:0]       rsp_angle_change,
   output logic                                      rsp_degenerate
);
   localparam int N = hss_pkg::NumCells;

   logic              adv;
   logic              chain_valid [N+1];
   hss_pkg::item_type chain_item  [N+1];

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   hss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .pole_x    (req_pole_x),
      .pole_y    (req_pole_y),
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .end_x     (req_end_x),
      .end_y     (req_end_y),
      .out_valid (chain_valid[0]),
      .out_item  (chain_item[0])
   );

   for (genvar g = 0; g < N; g++) begin : g_cell
      hss_cell #(
         .CORDIC_STAGES (CORDIC_STAGES),
         .STAGE         (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[g]),
         .in_item   (chain_item[g]),
         .out_valid (chain_valid[g+1]),
         .out_item  (chain_item[g+1])
      );
   end

   hss_back u_back (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (chain_valid[N]),
      .in_item      (chain_item[N]),
      .out_valid    (rsp_valid),
      .log_ratio    (rsp_log_ratio),
      .angle_change (rsp_angle_change),
      .degenerate   (rsp_degenerate)
   );

`ifndef SYNTHESIS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_log_ratio == '0 && rsp_angle_change == '0)
      else $error("degenerate word with nonzero result");

   a_ang_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_change <= 19'sd205887 && rsp_angle_change >= -19'sd205887)
      else $error("angle out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");
`endif
endmodule
`default_nettype wire

FILE: src/hss_front.sv
`timescale 1ns / 1ps
`default_nettype none
module hss_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 adv,
   input  wire logic                                 in_valid,
   input  wire logic signed [hss_pkg::CoordW-1:0]    pole_x,
   input  wire logic signed [hss_pkg::CoordW-1:0]    pole_y,
   input  wire logic signed [hss_pkg::CoordW-1:0]    start_x,
   input  wire logic signed [hss_pkg::CoordW-1:0]    start_y,
   input  wire logic signed [hss_pkg::CoordW-1:0]    end_x,
   input  wire logic signed [hss_pkg::CoordW-1:0]    end_y,
   output logic                                      out_valid,
   output hss_pkg::item_type                         out_item
);
   localparam int DW = hss_pkg::DeltaW;
   localparam int SW = hss_pkg::SqW;
   localparam int CW = hss_pkg::CordW;

   logic [3:0] valid_ff, valid_in;

   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [DW-1:0] ax_in, ay_in, bx_in, by_in;
   logic                 degen1_ff, degen1_in;

   logic signed [SW-1:0] sqax_ff, sqay_ff, sqbx_ff, sqby_ff;
   logic signed [DW-1:0] rax_ff, ray_ff, rbx_ff, rby_ff;
   logic signed [DW-1:0] rax_in, ray_in, rbx_in, rby_in;
   logic signed [CW-1:0] raz_ff, rbz_ff, raz_in, rbz_in;
   logic                 degen2_ff;

   logic [SW-1:0]        d2a_ff, d2b_ff;
   logic signed [DW-1:0] sax_ff, say_ff, sbx_ff, sby_ff;
   logic signed [CW-1:0] saz_ff, sbz_ff;
   logic                 degen3_ff;

   hss_pkg::item_type    item_ff, item_in;

   function automatic void prerot(
      input  logic signed [DW-1:0] dx,
      input  logic signed [DW-1:0] dy,
      output logic signed [DW-1:0] rx,
      output logic signed [DW-1:0] ry,
      output logic signed [CW-1:0] rz
   );
      rx = dx;
      ry = dy;
      rz = '0;
      if (dx < 0) begin
         if (dy >= 0) begin
            rx = dy;
            ry = -dx;
            rz = hss_pkg::HalfPi;
         end else begin
            rx = -dy;
            ry = dx;
            rz = -hss_pkg::HalfPi;
         end
      end
   endfunction

   function automatic hss_pkg::lane_type lane_init(
      input logic [SW-1:0]         d2,
      input logic signed [DW-1:0]  rx,
      input logic signed [DW-1:0]  ry,
      input logic signed [CW-1:0]  rz
   );
      hss_pkg::lane_type    l;
      logic [hss_pkg::ExpW-1:0] e;
      logic [SW+30:0]       w;
      e = '0;
      for (int k = 0; k < SW; k++) begin
         if (d2[k]) e = hss_pkg::ExpW'(k);
      end
      w = {31'b0, d2} << 31;
      w = w >> e;
      l.x    = CW'(rx) <<< 12;
      l.y    = CW'(ry) <<< 12;
      l.z    = rz;
      l.m    = w[hss_pkg::MantW-1:0];
      l.e    = e;
      l.frac = '0;
      return l;
   endfunction

   always_comb begin
      ax_in = DW'(start_x) - DW'(pole_x);
      ay_in = DW'(start_y) - DW'(pole_y);
      bx_in = DW'(end_x) - DW'(pole_x);
      by_in = DW'(end_y) - DW'(pole_y);
      degen1_in = (ax_in == '0 && ay_in == '0) || (bx_in == '0 && by_in == '0);
      prerot(ax_ff, ay_ff, rax_in, ray_in, raz_in);
      prerot(bx_ff, by_ff, rbx_in, rby_in, rbz_in);
      item_in.a     = lane_init(d2a_ff, sax_ff, say_ff, saz_ff);
      item_in.b     = lane_init(d2b_ff, sbx_ff, sby_ff, sbz_ff);
      item_in.degen = degen3_ff;
      valid_in = {valid_ff[2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         bx_ff     <= bx_in;
         by_ff     <= by_in;
         degen1_ff <= degen1_in;

         sqax_ff   <= SW'(ax_ff) * SW'(ax_ff);
         sqay_ff   <= SW'(ay_ff) * SW'(ay_ff);
         sqbx_ff   <= SW'(bx_ff) * SW'(bx_ff);
         sqby_ff   <= SW'(by_ff) * SW'(by_ff);
         rax_ff    <= rax_in;
         ray_ff    <= ray_in;
         raz_ff    <= raz_in;
         rbx_ff    <= rbx_in;
         rby_ff    <= rby_in;
         rbz_ff    <= rbz_in;
         degen2_ff <= degen1_ff;

         d2a_ff    <= SW'(unsigned'(sqax_ff) + unsigned'(sqay_ff));
         d2b_ff    <= SW'(unsigned'(sqbx_ff) + unsigned'(sqby_ff));
         sax_ff    <= rax_ff;
         say_ff    <= ray_ff;
         saz_ff    <= raz_ff;
         sbx_ff    <= rbx_ff;
         sby_ff    <= rby_ff;
         sbz_ff    <= rbz_ff;
         degen3_ff <= degen2_ff;

         item_ff   <= item_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_item  = item_ff;
endmodule
`default_nettype wire

FILE: src/hss_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module hss_cell #(
   parameter int CORDIC_STAGES = hss_pkg::CordicStagesDef,
   parameter int STAGE         = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire hss_pkg::item_type in_item,
   output logic                   out_valid,
   output hss_pkg::item_type      out_item
);
   localparam int MW = hss_pkg::MantW;

   logic              valid_ff;
   hss_pkg::item_type item_ff, item_in;

   function automatic hss_pkg::lane_type step(input hss_pkg::lane_type l);
      hss_pkg::lane_type             r;
      logic [2*MW-1:0]               sq;
      logic [MW:0]                   t;
      logic signed [hss_pkg::CordW-1:0] xs, ys;
      r  = l;
      sq = (2*MW)'(l.m) * (2*MW)'(l.m);
      t  = sq[2*MW-1:MW-1];
      if (t[MW]) begin
         r.m    = t[MW:1];
         r.frac = {l.frac[hss_pkg::LogFrac-2:0], 1'b1};
      end else begin
         r.m    = t[MW-1:0];
         r.frac = {l.frac[hss_pkg::LogFrac-2:0], 1'b0};
      end
      if (STAGE < CORDIC_STAGES) begin
         xs = l.x >>> STAGE;
         ys = l.y >>> STAGE;
         if (l.y >= 0) begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + hss_pkg::atan_q29(STAGE);
         end else begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - hss_pkg::atan_q29(STAGE);
         end
      end
      return r;
   endfunction

   always_comb begin
      item_in.a     = step(in_item.a);
      item_in.b     = step(in_item.b);
      item_in.degen = in_item.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule
`default_nettype wire

FILE: src/hss_back.sv
`timescale 1ns / 1ps
`default_nettype none
module hss_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 adv,
   input  wire logic                                 in_valid,
   input  wire hss_pkg::item_type                    in_item,
   output logic                                      out_valid,
   output logic signed [hss_pkg::LogOutW-1:0]        log_ratio,
   output logic signed [hss_pkg::AngOutW-1:0]        angle_change,
   output logic                                      degenerate
);
   localparam int LW = hss_pkg::LogW;
   localparam int WW = hss_pkg::WrapW;
   localparam int PW = hss_pkg::ProdW;

   logic [1:0] valid_ff;
   logic       rsp_valid_ff;

   logic signed [LW:0]   diff_ff, diff_in;
   logic signed [WW-1:0] d_ff, d_in;
   logic                 degen1_ff;

   logic [PW-1:0]        prod_ff, prod_in;
   logic                 neg_ff;
   logic signed [WW-1:0] best_ff, best_in;
   logic                 degen2_ff;

   logic signed [hss_pkg::LogOutW-1:0] lr_ff, lr_in;
   logic signed [hss_pkg::AngOutW-1:0] ang_ff, ang_in;
   logic                               degen_ff;

   logic [LW-1:0]        mag;
   logic signed [WW-1:0] lo, hi;
   logic [WW-1:0]        abs_d, abs_lo, abs_hi, abs_best;
   logic [PW-1:0]        lr_sum;
   logic [WW-1:0]        ang_sum;

   always_comb begin
      diff_in = signed'({1'b0, in_item.b.e, in_item.b.frac})
              - signed'({1'b0, in_item.a.e, in_item.a.frac});
      d_in    = WW'(in_item.b.z) - WW'(in_item.a.z);

      mag     = diff_ff[LW] ? LW'(-diff_ff) : LW'(diff_ff);
      prod_in = PW'(mag) * PW'(hss_pkg::HalfLn2);

      // |d| < 2*pi + eps, so only d and d -/+ 2*pi can be nearest
      lo     = d_ff - hss_pkg::TwoPi;
      hi     = d_ff + hss_pkg::TwoPi;
      abs_d  = d_ff[WW-1] ? WW'(-d_ff) : WW'(d_ff);
      abs_lo = lo[WW-1] ? WW'(-lo) : WW'(lo);
      abs_hi = hi[WW-1] ? WW'(-hi) : WW'(hi);
      best_in  = d_ff;
      abs_best = abs_d;
      if (abs_lo < abs_best) begin
         best_in  = lo;
         abs_best = abs_lo;
      end
      if (abs_hi < abs_best) begin
         best_in = hi;
      end

      lr_sum  = prod_ff + (PW'(1) << 39);
      lr_in   = hss_pkg::LogOutW'(lr_sum >> 40);
      if (neg_ff) lr_in = -lr_in;
      ang_sum = (best_ff[WW-1] ? WW'(-best_ff) : WW'(best_ff)) + WW'(4096);
      ang_in  = hss_pkg::AngOutW'(ang_sum >> 13);
      if (best_ff[WW-1]) ang_in = -ang_in;
      if (degen2_ff) begin
         lr_in  = '0;
         ang_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[0], in_valid};
         rsp_valid_ff <= valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff   <= diff_in;
         d_ff      <= d_in;
         degen1_ff <= in_item.degen;
         prod_ff   <= prod_in;
         neg_ff    <= diff_ff[LW];
         best_ff   <= best_in;
         degen2_ff <= degen1_ff;
         lr_ff     <= lr_in;
         ang_ff    <= ang_in;
         degen_ff  <= degen2_ff;
      end
   end

   assign out_valid    = rsp_valid_ff;
   assign log_ratio    = lr_ff;
   assign angle_change = ang_ff;
   assign degenerate   = degen_ff;
endmodule
`default_nettype wire

FILE: verif/hss_checker.sv
`timescale 1ns / 1ps
module hss_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [hss_pkg::CoordW-1:0]     req_pole_x,
   input  logic signed [hss_pkg::CoordW-1:0]     req_pole_y,
   input  logic signed [hss_pkg::CoordW-1:0]     req_start_x,
   input  logic signed [hss_pkg::CoordW-1:0]     req_start_y,
   input  logic signed [hss_pkg::CoordW-1:0]     req_end_x,
   input  logic signed [hss_pkg::CoordW-1:0]     req_end_y,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [hss_pkg::LogOutW-1:0]    rsp_log_ratio,
   input  logic signed [hss_pkg::AngOutW-1:0]    rsp_angle_change,
   input  logic                                  rsp_degenerate,
   output int                                    errors,
   output int                                    pending
);
   localparam int Stages = hss_pkg::CordicStagesDef;
   localparam longint LogLim = 786432;
   localparam longint AngLim = 205887;

   typedef struct {
      logic signed [hss_pkg::LogOutW-1:0] log_ratio;
      logic signed [hss_pkg::AngOutW-1:0] angle_change;
      logic                               degenerate;
   } term_t;

   term_t  term_q[$];
   longint pi_fx;
   longint atan_tab[0:63];

   function automatic longint arctan_recip(longint unsigned n);
      longint unsigned p, k;
      longint acc;
      p = (64'd1 << 60) / n;
      k = 0;
      acc = 0;
      while (p != 0) begin
         if (k[0]) acc -= longint'(p / (2 * k + 1));
         else acc += longint'(p / (2 * k + 1));
         p = p / (n * n);
         k++;
      end
      return acc;
   endfunction

   function automatic longint arctan_pow2(int i);
      longint acc;
      longint unsigned ex, t;
      acc = 0;
      for (int k = 0; k < 64; k++) begin
         ex = i * (2 * k + 1);
         if (ex > 60) break;
         t = (64'd1 << (60 - ex)) / (2 * k + 1);
         if (k % 2) acc -= longint'(t);
         else acc += longint'(t);
      end
      return (acc + (64'sd1 <<< 30)) >>> 31;
   endfunction

   initial begin
      pi_fx = (4 * arctan_recip(5) - arctan_recip(239) + (64'sd1 <<< 28)) >>> 29;
      atan_tab[0] = (pi_fx + 2) >>> 2;
      for (int i = 1; i < 64; i++) atan_tab[i] = arctan_pow2(i);
   end

   function automatic longint vector_angle(longint dx, longint dy);
      longint x, y, z, t, xs, ys;
      x = dx * 4096;
      y = dy * 4096;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = (pi_fx + 1) >>> 1;
         end else begin
            x = -y; y = t; z = -((pi_fx + 1) >>> 1);
         end
      end
      for (int i = 0; i < Stages; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z += atan_tab[i];
         end else begin
            x = x - ys; y = y + xs; z -= atan_tab[i];
         end
      end
      return z;
   endfunction

   function automatic longint log2_fx(longint unsigned d2);
      int e;
      longint unsigned m, frac;
      e = 0;
      frac = 0;
      while (e < 63 && (d2 >> (e + 1)) != 0) e++;
      m = (e <= 31) ? (d2 << (31 - e)) : (d2 >> (e - 31));
      for (int i = 0; i < hss_pkg::LogFrac; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1; frac |= 1;
         end
      end
      return longint'((longint'(e) << hss_pkg::LogFrac) | frac);
   endfunction

   function automatic longint clip(longint v, longint lim);
      return v > lim ? lim : (v < -lim ? -lim : v);
   endfunction

   function automatic term_t segment_term(longint px, longint py, longint sx, longint sy,
                                          longint ex, longint ey);
      term_t  r;
      longint ax, ay, bx, by, diff, lr, d, best, cand, ang;
      longint unsigned mag, prod;
      ax = sx - px; ay = sy - py; bx = ex - px; by = ey - py;
      if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
         r.log_ratio = '0; r.angle_change = '0; r.degenerate = 1'b1;
         return r;
      end
      diff = log2_fx(bx * bx + by * by) - log2_fx(ax * ax + ay * ay);
      mag = diff < 0 ? -diff : diff;
      prod = (mag * 64'd1488522236 + (64'd1 << 39)) >> 40;
      lr = clip(diff < 0 ? -longint'(prod) : longint'(prod), LogLim);
      d = vector_angle(bx, by) - vector_angle(ax, ay);
      best = d;
      for (int k = 1; k <= 3; k++) begin
         cand = d - k * 2 * pi_fx;
         if ((cand < 0 ? -cand : cand) < (best < 0 ? -best : best)) best = cand;
         cand = d + k * 2 * pi_fx;
         if ((cand < 0 ? -cand : cand) < (best < 0 ? -best : best)) best = cand;
      end
      mag = best < 0 ? -best : best;
      mag = (mag + 4096) >> 13;
      ang = clip(best < 0 ? -longint'(mag) : longint'(mag), AngLim);
      r.log_ratio = lr[hss_pkg::LogOutW-1:0];
      r.angle_change = ang[hss_pkg::AngOutW-1:0];
      r.degenerate = 1'b0;
      return r;
   endfunction

   initial begin
      errors = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      term_t want;
      if (!reset) begin
         if (req_valid && req_ready)
            term_q.insert(term_q.size(),
                          segment_term(req_pole_x, req_pole_y, req_start_x, req_start_y,
                                       req_end_x, req_end_y));
         if (rsp_valid && rsp_ready) begin
            if (term_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected rsp word at %0t", $realtime);
            end else begin
               want = term_q.pop_front();
               if (want.log_ratio !== rsp_log_ratio || want.angle_change !== rsp_angle_change
                   || want.degenerate !== rsp_degenerate) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch at %0t: exp lr=%0d ang=%0d dg=%0b got lr=%0d ang=%0d dg=%0b",
                              $realtime, want.log_ratio, want.angle_change, want.degenerate,
                              rsp_log_ratio, rsp_angle_change, rsp_degenerate);
               end
            end
         end
      end
      pending = term_q.size();
   end
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [hss_pkg::CoordW-1:0] req_pole_x = '0, req_pole_y = '0;
   logic signed [hss_pkg::CoordW-1:0] req_start_x = '0, req_start_y = '0;
   logic signed [hss_pkg::CoordW-1:0] req_end_x = '0, req_end_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [hss_pkg::LogOutW-1:0] rsp_log_ratio;
   logic signed [hss_pkg::AngOutW-1:0] rsp_angle_change;
   logic rsp_degenerate;
   int   errors, pending;
   logic quiet = 1'b0;
   logic held_off = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   homotopy_segment_signature_top dut (.*);

   hss_checker chk (.*);

   task automatic send(input int px, input int py, input int sx, input int sy,
                       input int ex, input int ey);
      req_valid <= 1'b1;
      req_pole_x <= hss_pkg::CoordW'(px); req_pole_y <= hss_pkg::CoordW'(py);
      req_start_x <= hss_pkg::CoordW'(sx); req_start_y <= hss_pkg::CoordW'(sy);
      req_end_x <= hss_pkg::CoordW'(ex); req_end_y <= hss_pkg::CoordW'(ey);
      do @(posedge clock); while (!req_ready);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   function automatic int near(int c, int span);
      int v;
      v = c + $signed($urandom_range(0, 2 * span)) - span;
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   // receiver: random stall bursts, one long hold-off, none near the end
   initial begin
      @(negedge reset);
      while (!held_off) @(posedge clock);
      rsp_ready <= 1'b0;
      repeat (200) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
         if (!quiet) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin
      #5ms;
      $display("tb_top failed");
      $finish;
   end

   initial begin
      int px, py, sx, sy, ex, ey, r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      held_off <= 1'b1;
      // directed: extremes, endpoint on pole, opposite directions, all quadrants
      send(-32768, -32768, 32767, 32767, -32768, 32767);
      send(32767, 32767, -32768, -32768, 32767, -32768);
      send(0, 0, 0, 0, 5, 7);
      send(10, -3, 40, 2, 10, -3);
      send(-7, -7, -7, -7, -7, -7);
      send(0, 0, -1, 0, 1, 0);
      send(0, 0, 1, 0, -1, 0);
      send(0, 0, 0, 1, 0, -1);
      send(0, 0, -1, 1, -1, -1);
      send(0, 0, -1, -1, -1, 1);
      send(0, 0, 1, 1, -1, -1);
      send(0, 0, 1, 0, 1, 0);
      send(0, 0, 1, 0, 32767, 0);
      send(32767, 0, 32766, 0, -32768, 0);
      send(-32768, 0, 32767, 0, -32767, 1);
      send(0, -32768, 0, 32767, 1, -32768);
      send(100, 100, 101, 99, 99, 101);
      send(-5, 3, -5, 4, -5, 2);
      for (int n = 0; n < 1150; n++) begin
         if (n > 1000) quiet = 1'b1;
         r = $urandom_range(0, 9);
         px = $signed(16'($urandom));
         py = $signed(16'($urandom));
         if (r < 4) begin
            sx = near(px, 64); sy = near(py, 64); ex = near(px, 64); ey = near(py, 64);
         end else if (r < 8) begin
            sx = $signed(16'($urandom)); sy = $signed(16'($urandom));
            ex = $signed(16'($urandom)); ey = $signed(16'($urandom));
         end else begin
            sx = near(px, 2); sy = near(py, 2); ex = near(px, 2); ey = near(py, 2);
            if (r == 9) begin
               ex = px; ey = py;
            end
         end
         send(px, py, sx, sy, ex, ey);
      end
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end
endmodule
